// ----- hw/rtl/apt_pkg.sv -----
// Shared types and constants for the affine point transform.
package apt_pkg;

  // Fraction bits of every fixed-point format in the block
  localparam int FRAC_BITS = 16;

  // Register stages between input and output
  localparam int NUM_STAGES = 4;

  // Width of the configuration register index
  localparam int CFG_IDX_WIDTH = 3;

  // Fixed-point 1.0 before truncation to the coefficient field
  localparam int FIXED_ONE = 1 << FRAC_BITS;

  // Configuration register map
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ROW0    = 3'd0,
    CFG_ROW1    = 3'd1,
    CFG_ROW2    = 3'd2,
    CFG_TRANS_X = 3'd3,
    CFG_TRANS_Y = 3'd4,
    CFG_TRANS_Z = 3'd5
  } cfg_reg_e;

  // Per-stage load enables, driven by the pipeline control
  typedef struct packed {
    logic go1;
    logic go2;
    logic go3;
    logic go4;
  } stage_go_t;

endpackage

// ----- hw/rtl/apt_cfg.sv -----
// Configuration register file: three coefficient rows and three translations.
module apt_cfg #(
  parameter int COORD_WIDTH = 32,
  parameter int COEFF_WIDTH = 20,
  parameter int CFG_WIDTH   = 60
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     wr_en_i,
  input  logic [apt_pkg::CFG_IDX_WIDTH-1:0]        wr_idx_i,
  input  logic [CFG_WIDTH-1:0]                     wr_data_i,
  output logic [3*COEFF_WIDTH-1:0]                 row_o   [3],
  output logic signed [COORD_WIDTH-1:0]            trans_o [3]
);
  import apt_pkg::*;

  localparam int RowWidth = 3 * COEFF_WIDTH;
  localparam logic [RowWidth-1:0] OneField = RowWidth'(COEFF_WIDTH'(FIXED_ONE));

  logic [RowWidth-1:0]           row_q   [3];
  logic signed [COORD_WIDTH-1:0] trans_q [3];

  // Register writes; reset loads the identity matrix and zero translation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= OneField;
      row_q[1]   <= OneField << COEFF_WIDTH;
      row_q[2]   <= OneField << (2 * COEFF_WIDTH);
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
    end else if (wr_en_i) begin
      case (cfg_reg_e'(wr_idx_i))
        CFG_ROW0:    row_q[0]   <= wr_data_i[RowWidth-1:0];
        CFG_ROW1:    row_q[1]   <= wr_data_i[RowWidth-1:0];
        CFG_ROW2:    row_q[2]   <= wr_data_i[RowWidth-1:0];
        CFG_TRANS_X: trans_q[0] <= $signed(wr_data_i[COORD_WIDTH-1:0]);
        CFG_TRANS_Y: trans_q[1] <= $signed(wr_data_i[COORD_WIDTH-1:0]);
        CFG_TRANS_Z: trans_q[2] <= $signed(wr_data_i[COORD_WIDTH-1:0]);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign row_o   = row_q;
  assign trans_o = trans_q;

endmodule

// ----- hw/rtl/apt_row_dp.sv -----
// Datapath of one output row: multiply, realign, accumulate, saturate.
module apt_row_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int COEFF_WIDTH = 20
) (
  input  logic                            clk_i,
  input  apt_pkg::stage_go_t              go_i,
  input  logic signed [COORD_WIDTH-1:0]   p_i   [3],
  input  logic [3*COEFF_WIDTH-1:0]        row_i,
  input  logic signed [COORD_WIDTH-1:0]   trans_i,
  output logic signed [COORD_WIDTH-1:0]   res_o,
  output logic                            sat_o
);
  import apt_pkg::*;

  // Coordinate split: high part keeps an extra sign bit, low part is unsigned
  localparam int HiWidth   = COORD_WIDTH + 1 - FRAC_BITS;
  localparam int LoWidth   = FRAC_BITS + 1;
  localparam int PHiWidth  = HiWidth + COEFF_WIDTH;
  localparam int PLoWidth  = LoWidth + COEFF_WIDTH;
  localparam int TermWidth = PHiWidth + 1;
  localparam int SumWidth  = ((TermWidth > COORD_WIDTH) ? TermWidth : COORD_WIDTH) + 2;

  localparam logic signed [COORD_WIDTH-1:0] MaxVal = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MinVal = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PHiWidth-1:0]  phi_d  [3];
  logic signed [PHiWidth-1:0]  phi_q  [3];
  logic signed [PLoWidth-1:0]  plo_d  [3];
  logic signed [PLoWidth-1:0]  plo_q  [3];
  logic signed [TermWidth-1:0] term_d [3];
  logic signed [TermWidth-1:0] term_q [3];
  logic signed [SumWidth-1:0]  sum_d;
  logic signed [SumWidth-1:0]  sum_q;
  logic signed [COORD_WIDTH-1:0] res_d;
  logic signed [COORD_WIDTH-1:0] res_q;
  logic                          sat_d;
  logic                          sat_q;

  // Stage 1: partial products of the high and low coordinate parts
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [COORD_WIDTH:0]          a_ext;
      logic signed [HiWidth-1:0]     hi;
      logic signed [LoWidth-1:0]     lo;
      logic signed [COEFF_WIDTH-1:0] k;
      a_ext    = {p_i[c][COORD_WIDTH-1], p_i[c]};
      hi       = $signed(a_ext[COORD_WIDTH:FRAC_BITS]);
      lo       = $signed({1'b0, a_ext[FRAC_BITS-1:0]});
      k        = $signed(row_i[c*COEFF_WIDTH +: COEFF_WIDTH]);
      phi_d[c] = hi * k;
      plo_d[c] = lo * k;
    end
  end

  // Stage 2: floor of each product scaled down by the fraction bits
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      term_d[c] = TermWidth'(phi_q[c]) + TermWidth'(plo_q[c] >>> FRAC_BITS);
    end
  end

  // Stage 3: exact sum of the three terms and the translation
  assign sum_d = SumWidth'(term_q[0]) + SumWidth'(term_q[1]) + SumWidth'(term_q[2])
               + SumWidth'(trans_i);

  // Stage 4: clamp to the coordinate range
  always_comb begin
    if (sum_q > SumWidth'(MaxVal)) begin
      res_d = MaxVal;
      sat_d = 1'b1;
    end else if (sum_q < SumWidth'(MinVal)) begin
      res_d = MinVal;
      sat_d = 1'b1;
    end else begin
      res_d = sum_q[COORD_WIDTH-1:0];
      sat_d = 1'b0;
    end
  end

  // Stage registers, loaded when the control lets each stage advance
  always_ff @(posedge clk_i) begin
    if (go_i.go1) begin
      phi_q <= phi_d;
      plo_q <= plo_d;
    end
    if (go_i.go2) begin
      term_q <= term_d;
    end
    if (go_i.go3) begin
      sum_q <= sum_d;
    end
    if (go_i.go4) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

// ----- hw/rtl/affine_point_transform.sv -----
// An input point passes the product, term, sum and clamp registers before result valid.
// Throughput: one point per cycle unless the output stalls; stalls squeeze out bubbles.
// The deepest path is the coefficient multiply of stage one.
// Reset clears all stage valid bits, loads the identity matrix and zero translation.
// Top level: handshake control, configuration and three row datapaths.
module affine_point_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int COEFF_WIDTH = 20,
  localparam int CfgWidth =
    (3 * COEFF_WIDTH > COORD_WIDTH) ? 3 * COEFF_WIDTH : COORD_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [apt_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [CfgWidth-1:0]                 cfg_data_i,
  // input point channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       x_in_i,
  input  logic signed [COORD_WIDTH-1:0]       y_in_i,
  input  logic signed [COORD_WIDTH-1:0]       z_in_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_WIDTH-1:0]       x_out_o,
  output logic signed [COORD_WIDTH-1:0]       y_out_o,
  output logic signed [COORD_WIDTH-1:0]       z_out_o,
  output logic                                overflow_o
);
  import apt_pkg::*;

  logic [NUM_STAGES-1:0]          v_q;
  stage_go_t                      go;
  logic [3*COEFF_WIDTH-1:0]       row   [3];
  logic signed [COORD_WIDTH-1:0]  trans [3];
  logic signed [COORD_WIDTH-1:0]  point [3];
  logic signed [COORD_WIDTH-1:0]  res   [3];
  logic [2:0]                     sat;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  apt_cfg #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEFF_WIDTH (COEFF_WIDTH),
    .CFG_WIDTH   (CfgWidth)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .row_o     (row),
    .trans_o   (trans)
  );

  // A stage advances when it is empty or the stage after it advances
  assign go.go4 = !v_q[3] || out_ready_i;
  assign go.go3 = !v_q[2] || go.go4;
  assign go.go2 = !v_q[1] || go.go3;
  assign go.go1 = !v_q[0] || go.go2;

  assign in_ready_o = go.go1;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go.go1) v_q[0] <= in_valid_i;
      if (go.go2) v_q[1] <= v_q[0];
      if (go.go3) v_q[2] <= v_q[1];
      if (go.go4) v_q[3] <= v_q[2];
    end
  end

  assign point[0] = x_in_i;
  assign point[1] = y_in_i;
  assign point[2] = z_in_i;

  // One datapath per output component
  for (genvar r = 0; r < 3; r++) begin : g_row
    apt_row_dp #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
    ) u_row (
      .clk_i   (clk_i),
      .go_i    (go),
      .p_i     (point),
      .row_i   (row[r]),
      .trans_i (trans[r]),
      .res_o   (res[r]),
      .sat_o   (sat[r])
    );
  end

  assign out_valid_o = v_q[NUM_STAGES-1];
  assign x_out_o     = res[0];
  assign y_out_o     = res[1];
  assign z_out_o     = res[2];
  assign overflow_o  = |sat;

  localparam logic signed [COORD_WIDTH-1:0] MaxOut = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MinOut = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Input back-pressure only when every stage is full and the output is stalled
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("input stalled while the pipeline has room");

  // The output stage fills only from a valid stage three
  a_valid_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v_q[3]) |-> $past(v_q[2]))
    else $error("output valid without a preceding stage");

  // A flagged overflow shows a clamped component
  a_ovf_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      (x_out_o == MaxOut) || (x_out_o == MinOut) ||
      (y_out_o == MaxOut) || (y_out_o == MinOut) ||
      (z_out_o == MaxOut) || (z_out_o == MinOut))
    else $error("overflow flagged without a saturated component");

endmodule
